[rtl/core/assert_macros.svh]
// Assertion macros used by the RTL of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/sdra_pkg.sv]
// Types and constants of the signed decimal right-align block.
`default_nettype none
package sdra_pkg;

  // Configuration register indexes.
  localparam logic CFG_MINUS_CODE = 1'b0;
  localparam logic CFG_BLANK_CODE = 1'b1;

  localparam logic signed [7:0] MINUS_CODE_RST = 8'sd10;
  localparam logic signed [7:0] BLANK_CODE_RST = 8'sd11;

  // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x.
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam logic [3:0]  RADIX       = 4'd10;

  typedef struct packed {
    logic signed [31:0] number;
    logic [4:0]         field_width;
  } in_t;

  typedef struct packed {
    logic [3:0]         position;
    logic signed [7:0]  symbol;
    logic               last;
  } out_t;

endpackage
`default_nettype wire

[rtl/core/signed_decimal_right_align.sv]
// Signed decimal right-align formatter: lays a 32-bit value out in a field of cells.
// An input transfer is followed by S_MAG (magnitude) and S_DIV (reciprocal multiplication), then
// S_EMIT loads the first cell into the output register. A new item is taken only in S_IDLE. Each
// cell needs one pass through the shared multiplier and an S_EMIT step that waits for a free slot.
// Reset (synchronous, rst_n low) empties the sequencer and output register and restores the codes.
`default_nettype none
`include "assert_macros.svh"
module signed_decimal_right_align #(
  parameter int MAX_WIDTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [7:0]    cfg_wdata,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire sdra_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output sdra_pkg::out_t     out_data
);
  import sdra_pkg::*;

  // Width of the internal cell counter; positions are reported modulo 16.
  localparam int PW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAG  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic signed [7:0] minus_code_r, blank_code_r;
  logic [31:0]       rest_r, rest_nxt;      // Raw value at first, then its magnitude, then the running quotient.
  logic [31:0]       quo_r, quo_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic              neg_r, neg_nxt;
  logic              first_r, first_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic              in_xfer;
  logic              slot_free;
  logic [6:0]        width_clamped;
  logic [63:0]       prod;
  logic [31:0]       quo_times_ten;
  logic [31:0]       digit_full;
  logic              use_digit;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  // The output register can take a new cell when it is empty or its cell is leaving now.
  assign slot_free = !out_valid_r || !out_stall;

  // A zero width is one cell; anything above MAX_WIDTH saturates.
  always_comb begin
    width_clamped = {2'b00, in_data.field_width};
    if (width_clamped == 7'd0) begin
      width_clamped = 7'd1;
    end else if (width_clamped > 7'(MAX_WIDTH)) begin
      width_clamped = 7'(MAX_WIDTH);
    end
  end

  // The shared unit: one reciprocal multiplication per cell, registered into quo_r.
  assign prod          = rest_r * RECIP_10;
  assign quo_times_ten = (quo_r << 3) + (quo_r << 1);
  assign digit_full    = rest_r - quo_times_ten;
  // The units cell always shows a digit; further cells while the quotient is nonzero.
  assign use_digit     = first_r || (rest_r != 32'd0);

  always_comb begin
    state_nxt     = state_r;
    rest_nxt      = rest_r;
    quo_nxt       = quo_r;
    pos_nxt       = pos_r;
    neg_nxt       = neg_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // The waiting cell leaves on its transfer unless a new one replaces it below.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          rest_nxt  = in_data.number;
          neg_nxt   = in_data.number[31];
          pos_nxt   = PW'(width_clamped - 7'd1);
          first_nxt = 1'b1;
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        // Two's complement negation; the most negative value becomes unsigned 2^31.
        if (neg_r) begin
          rest_nxt = 32'd0 - rest_r;
        end
        state_nxt = S_DIV;
      end
      S_DIV: begin
        quo_nxt   = {3'b000, prod[63:RECIP_SHIFT]};
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.position = 4'(pos_r);
          out_data_nxt.last     = (pos_r == '0);
          if (use_digit) begin
            out_data_nxt.symbol = {4'b0000, digit_full[3:0]};
            rest_nxt            = quo_r;
          end else if (neg_r) begin
            out_data_nxt.symbol = minus_code_r;
            neg_nxt             = 1'b0;
          end else begin
            out_data_nxt.symbol = blank_code_r;
          end
          first_nxt = 1'b0;
          if (pos_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = pos_r - PW'(1);
            state_nxt = S_DIV;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      minus_code_r <= MINUS_CODE_RST;
      blank_code_r <= BLANK_CODE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MINUS_CODE: minus_code_r <= cfg_wdata;
          CFG_BLANK_CODE: blank_code_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers carry no reset; the sequencer guards their use.
  always_ff @(posedge clk) begin
    rest_r     <= rest_nxt;
    quo_r      <= quo_nxt;
    pos_r      <= pos_nxt;
    neg_r      <= neg_nxt;
    first_r    <= first_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Once an item is taken, the block stays busy for at least the next cycle.
  `ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_xfer, in_stall, "idle after an input transfer")
  // The reciprocal division must always leave a remainder below ten.
  `ASSERT_IMPL(a_digit_range, clk, rst_n, (state_r == S_EMIT) && use_digit, digit_full < 32'd10, "remainder out of range")
  // The cell counter never exceeds the field.
  `ASSERT_IMPL(a_pos_range, clk, rst_n, state_r != S_IDLE, int'(pos_r) < MAX_WIDTH, "cell counter beyond the field")

endmodule
`default_nettype wire

[dv/signed_decimal_right_align_test.sv]
// Self-checking testbench for the signed decimal right-align formatter.
`timescale 1ns / 100ps

module signed_decimal_right_align_test;
  import sdra_pkg::*;

  localparam int MAX_CELLS     = 16;
  localparam int ITEMS_PER_RUN = 47;
  localparam int PHASES        = 4;
  // A number takes longest with the widest field, a stall burst on every cell and an input
  // gap before it; that is the worst case. Allow several times that for the whole run.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;

  // Tracks the code registers and predicts the cells that each number should produce,
  // then checks the cells coming out of the block against them in order.
  class format_scoreboard;
    localparam int unsigned DECIMAL_BASE = int'(sdra_pkg::RADIX);

    sdra_pkg::out_t    expected_cells[$];
    logic signed [7:0] minus_code;
    logic signed [7:0] blank_code;
    int                mismatches;
    int                cells_seen;
    int                numbers_seen;

    function new();
      minus_code   = sdra_pkg::MINUS_CODE_RST;
      blank_code   = sdra_pkg::BLANK_CODE_RST;
      mismatches   = 0;
      cells_seen   = 0;
      numbers_seen = 0;
    endfunction

    function void set_code(logic index, logic signed [7:0] code);
      if (index == sdra_pkg::CFG_MINUS_CODE) begin
        minus_code = code;
      end else begin
        blank_code = code;
      end
    endfunction

    // Lays the number out from the rightmost cell leftwards, as the block should.
    function void note_number(sdra_pkg::in_t item);
      sdra_pkg::out_t entry;
      logic [31:0]    magnitude;
      logic [31:0]    rest;
      logic           negative;
      int unsigned    width;
      int unsigned    pos;
      negative  = item.number[31];
      // The most negative value wraps back to itself, which read unsigned is 2^31.
      magnitude = negative ? (32'd0 - item.number) : item.number;
      width     = item.field_width;
      if (width == 0) width = 1;
      if (width > MAX_CELLS) width = MAX_CELLS;
      pos            = width - 1;
      entry.position = 4'(pos);
      entry.symbol   = 8'(magnitude % DECIMAL_BASE);
      entry.last     = (pos == 0);
      expected_cells.push_back(entry);
      rest = magnitude / DECIMAL_BASE;
      while (pos > 0) begin
        pos--;
        entry.position = 4'(pos);
        if (rest != 0) begin
          entry.symbol = 8'(rest % DECIMAL_BASE);
          rest         = rest / DECIMAL_BASE;
        end else if (negative) begin
          entry.symbol = minus_code;
          negative     = 1'b0;
        end else begin
          entry.symbol = blank_code;
        end
        entry.last = (pos == 0);
        expected_cells.push_back(entry);
      end
      numbers_seen++;
    endfunction

    function void check_cell(sdra_pkg::out_t got);
      sdra_pkg::out_t want;
      cells_seen++;
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected cell, expected none, actual pos %0d sym %0d last %0b",
                 $time, got.position, got.symbol, got.last);
        mismatches++;
        return;
      end
      want = expected_cells.pop_front();
      if (got.position !== want.position) begin
        $display("%0t: position mismatch, expected %0d, actual %0d",
                 $time, want.position, got.position);
        mismatches++;
      end
      if (got.symbol !== want.symbol) begin
        $display("%0t: symbol mismatch at position %0d, expected %0d, actual %0d",
                 $time, want.position, want.symbol, got.symbol);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch at position %0d, expected %0b, actual %0b",
                 $time, want.position, want.last, got.last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_cells.size();
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic cfg_we    = 1'b0;
  logic cfg_index = CFG_MINUS_CODE;
  logic [7:0] cfg_wdata = '0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  format_scoreboard board = new();

  // Percentage chances that a burst of idling starts on each side; zero turns it off.
  int gap_pct   = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int settings_used = 1;

  signed_decimal_right_align #(.MAX_WIDTH(MAX_CELLS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // The result side stalls in bursts. The first stalled cycle is set here and a random
  // remainder counted down in stall_left, so a burst can fall on any cell of a number.
  always @(posedge clk) begin
    if (!rst_n || stall_pct == 0) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99, 0) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(6, 0);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Every result transfer is checked against the oldest predicted cell. Values read here
  // are those from just before the edge, as the block sees them.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_cell(out_data);
    end
  end

  // Presents one number and holds it until the transfer happens. Valid is left high so
  // that back-to-back numbers need no lowering; the caller lowers it for a gap.
  task automatic send_number(input logic signed [31:0] number, input logic [4:0] width);
    in_t item;
    item.number      = number;
    item.field_width = width;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    // The transfer has just happened at this edge, so the prediction is queued now.
    board.note_number(item);
  endtask

  // An occasional input gap before the next number.
  task automatic maybe_gap();
    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every predicted cell has come out.
  task automatic drain_cells();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Writes both code registers back to back; only called while the block is idle.
  task automatic write_codes(input logic signed [7:0] minus, input logic signed [7:0] blank);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MINUS_CODE;
    cfg_wdata <= minus;
    @(posedge clk);
    board.set_code(CFG_MINUS_CODE, minus);
    cfg_index <= CFG_BLANK_CODE;
    cfg_wdata <= blank;
    @(posedge clk);
    board.set_code(CFG_BLANK_CODE, blank);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mixes short values, which leave room for sign and blanks, with full-range ones and
  // values sitting on a decade boundary or the ends of the range.
  function automatic logic signed [31:0] pick_number();
    logic signed [31:0] value;
    case ($urandom_range(5, 0))
      0: value = $urandom_range(99, 0);
      1: value = -32'($urandom_range(99, 1));
      2: value = 32'($urandom_range(99999, 0));
      3: value = -32'($urandom_range(9999999, 0));
      4: value = $urandom();
      default: begin
        case ($urandom_range(7, 0))
          0: value = 32'sh7FFF_FFFF;
          1: value = 32'sh8000_0000;
          2: value = 32'sh8000_0001;
          3: value = 32'sd1_000_000_000;
          4: value = -32'sd1_000_000_000;
          5: value = 32'sd999_999_999;
          6: value = -32'sd10;
          default: value = -32'sd1;
        endcase
      end
    endcase
    return value;
  endfunction

  // Mostly widths the block uses as given, sometimes ones that saturate.
  function automatic logic [4:0] pick_width();
    if ($urandom_range(9, 0) == 0) return 5'($urandom_range(31, 17));
    return 5'($urandom_range(16, 0));
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed numbers run with the codes straight out of reset, with light idling.
    gap_pct   = 20;
    stall_pct = 20;
    send_number(32'sd0, 5'd0);              // zero width behaves as one cell
    send_number(32'sd0, 5'd5);              // zero still shows its units digit
    send_number(-32'sd1, 5'd16);            // all input bits set
    send_number(32'sd7, 5'd31);             // widest code saturates
    send_number(32'sd42, 5'd17);            // just above the maximum width
    send_number(32'sh7FFF_FFFF, 5'd16);
    send_number(32'sh7FFF_FFFF, 5'd10);
    send_number(32'sh7FFF_FFFF, 5'd4);      // leading digits dropped
    send_number(32'sh8000_0000, 5'd16);     // magnitude of the most negative value
    maybe_gap();
    send_number(32'sh8000_0000, 5'd11);     // sign exactly fits
    send_number(32'sh8000_0000, 5'd10);     // sign dropped
    send_number(-32'sd123, 5'd3);           // digits fill the field, no room for sign
    send_number(-32'sd123, 5'd4);
    send_number(32'sd123, 5'd2);            // field too narrow for the digits
    send_number(-32'sd5, 5'd1);
    send_number(-32'sd5, 5'd2);
    maybe_gap();
    send_number(32'sd9, 5'd1);
    send_number(32'sd10, 5'd2);
    send_number(32'sd1_000_000_000, 5'd16);
    send_number(-32'sd1_000_000_000, 5'd11);
    send_number(32'sd100, 5'd8);            // trailing zero digits
    send_number(-32'sd8, 5'd0);

    // Random phases, each with its own code setting. The first three take in the extremes
    // and a pair where minus looks like a digit; the last has no idling at all.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_cells();
      case (phase)
        0: write_codes(-8'sd128, 8'sd127);
        1: write_codes(8'sd127, -8'sd128);
        2: write_codes(8'sd0, -8'sd1);
        default: write_codes(8'($urandom()), 8'($urandom()));
      endcase
      gap_pct   = (phase == PHASES - 1) ? 0 : 10 + 15 * phase;
      stall_pct = (phase == PHASES - 1) ? 0 : 40 - 12 * phase;
      for (int n = 0; n < ITEMS_PER_RUN; n++) begin
        maybe_gap();
        send_number(pick_number(), pick_width());
      end
    end

    // Let the last cells out, then watch a little longer for any stray transfer.
    drain_cells();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending() != 0) begin
      $display("%0t: %0d expected cells never arrived", $time, board.pending());
      board.mismatches++;
    end

    $display("Formatted %0d numbers into %0d checked cells under %0d code settings,",
             board.numbers_seen, board.cells_seen, settings_used);
    $display("with widths from zero to saturation and stalls on both channels.");
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sdra_pkg.sv
rtl/core/signed_decimal_right_align.sv
dv/signed_decimal_right_align_test.sv
